>>> hdl/bdks_pkg.sv
// Package for the bounded deque with key search: request and result beat types,
// request and status codes, and the control code that drives one storage cell.
// No dependencies.
package bdks_pkg;

    // Field widths of one request beat and one result beat.
    localparam int unsigned REQ_W    = 3;
    localparam int unsigned KEY_W    = 16;
    localparam int unsigned VALUE_W  = 20;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned COUNT_W  = 5;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd1;
    localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_FIND       = 3'd4;
    localparam logic [REQ_W-1:0] REQ_SET_VALUE  = 3'd5;
    localparam logic [REQ_W-1:0] REQ_FIND_MAX   = 3'd6;

    // Status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_KEY = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd3;

    // One stored entry.
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } t_entry;

    // One request beat.
    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [KEY_W-1:0]   item_key;
        logic [VALUE_W-1:0] item_value;
    } t_req;

    // One result beat.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [KEY_W-1:0]    out_key;
        logic [VALUE_W-1:0]  out_value;
        logic [COUNT_W-1:0]  stored_count;
    } t_result;

    // What a cell loads at the next clock edge.
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_FROM_PREV,
        CELL_FROM_NEXT,
        CELL_LOAD
    } t_cell_op;

    // Control word from the sequencer to one cell.
    typedef struct packed {
        t_cell_op op;
    } t_cell_ctl;

endpackage

>>> hdl/bdks_cell.sv
// One storage cell of the deque chain: holds a single (key, value) entry and
// takes its neighbor's entry, a new entry, or keeps its own each cycle.
// Depends on bdks_pkg.
module bdks_cell
    import bdks_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  t_entry    i_prev,
    input  t_entry    i_next,
    input  t_entry    i_load,
    output t_entry    o_entry
);

    t_entry r_entry;

    // Entry register; payload only, so no reset.
    always_ff @(posedge i_clk) begin
        unique case (i_ctl.op)
            CELL_HOLD:      r_entry <= r_entry;
            CELL_FROM_PREV: r_entry <= i_prev;
            CELL_FROM_NEXT: r_entry <= i_next;
            CELL_LOAD:      r_entry <= i_load;
            default:        r_entry <= r_entry;
        endcase
    end

    assign o_entry = r_entry;

endmodule

>>> hdl/bounded_deque_with_key_search_top.sv
// Top level of the bounded deque with key search: a row of storage cells in
// front-to-back order plus the sequencer that shifts, loads and rotates them.
// Depends on bdks_pkg and bdks_cell.
//
//  Channel   | Ports                        | Handshake
//  ----------+------------------------------+-------------------------------------
//  request   | i_req, start, busy           | beat taken when start && !busy
//  result    | o_result, o_valid            | one-cycle strobe, cannot be stalled
//
// Push, pop and unused codes do not hold busy; the result shows the cycle after
// the request beat. Find, set value and find max on a non-empty store rotate
// the whole cell chain once past the front cell, one position a cycle, so they
// hold busy through the whole rotation and the result shows the cycle after it.
// Find, set value and find max on an empty store answer like a push or pop, with status empty.
// Reset is synchronous and empties the store; cell contents are not cleared.
module bounded_deque_with_key_search_top
    import bdks_pkg::*;
#(
    parameter int unsigned CAPACITY = 16
)
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_req    i_req,
    output logic    busy,
    output logic    o_valid,
    output t_result o_result
);

    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned PW = $clog2(CAPACITY);

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

    t_state          r_state;
    logic [CW-1:0]   r_count;
    logic [PW-1:0]   r_pos;
    t_req            r_req;
    logic            r_hit;
    t_entry          r_best;
    logic            r_valid;
    t_result         r_result;

    t_state          n_state;
    logic [CW-1:0]   n_count;
    logic            n_hit;
    t_entry          n_best;
    logic            n_valid;
    t_result         n_result;

    t_entry          w_cell [CAPACITY];
    t_cell_ctl       w_ctl  [CAPACITY];
    t_entry          w_new;
    t_entry          w_head;
    t_entry          w_back;
    t_entry          w_wrap;
    logic [CW-1:0]   w_count_m1;
    logic            w_accept;
    logic            w_empty;
    logic            w_full;
    logic            w_push_back;
    logic            w_push_front;
    logic            w_pop_front;
    logic            w_scan;
    logic            w_pos_valid;
    logic            w_key_op;
    logic            w_match;
    logic            w_last;

    // Handshake and store status.
    assign busy       = (r_state == ST_SCAN);
    assign w_accept   = start && !busy;
    assign w_empty    = (r_count == '0);
    assign w_full     = (r_count == CW'(CAPACITY));
    assign w_count_m1 = r_count - CW'(1);

    assign w_new  = '{key: i_req.item_key, value: i_req.item_value};
    assign w_head = w_cell[0];
    assign w_back = w_cell[w_count_m1[PW-1:0]];

    // Chain moves requested in this cycle.
    assign w_push_back  = w_accept && (i_req.req_type == REQ_PUSH_BACK) && !w_full;
    assign w_push_front = w_accept && (i_req.req_type == REQ_PUSH_FRONT) && !w_full;
    assign w_pop_front  = w_accept && (i_req.req_type == REQ_POP_FRONT) && !w_empty;
    assign w_scan       = (r_state == ST_SCAN);

    // Scan compare at the front cell, which holds position r_pos.
    assign w_pos_valid = (CW'(r_pos) < r_count);
    assign w_key_op    = (r_req.req_type == REQ_FIND) || (r_req.req_type == REQ_SET_VALUE);
    assign w_match     = w_scan && w_key_op && w_pos_valid && !r_hit
                         && (w_head.key == r_req.item_key);
    assign w_last      = (r_pos == PW'(CAPACITY - 1));

    // Entry that wraps from the front cell to the back cell; set value rewrites it.
    always_comb begin
        w_wrap = w_head;
        if (w_match && (r_req.req_type == REQ_SET_VALUE)) begin
            w_wrap.value = r_req.item_value;
        end
    end

    // Cell chain.
    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        t_entry w_prev;
        t_entry w_next;

        if (gi == 0) begin : g_first
            assign w_prev = w_new;
        end else begin : g_mid_prev
            assign w_prev = w_cell[gi-1];
        end

        if (gi == CAPACITY - 1) begin : g_last
            assign w_next = w_wrap;
        end else begin : g_mid_next
            assign w_next = w_cell[gi+1];
        end

        // Per-cell move: shift, rotate, or load at the back slot.
        always_comb begin
            priority if (w_push_front) begin
                w_ctl[gi].op = CELL_FROM_PREV;
            end else if (w_pop_front || w_scan) begin
                w_ctl[gi].op = CELL_FROM_NEXT;
            end else if (w_push_back && (r_count == CW'(gi))) begin
                w_ctl[gi].op = CELL_LOAD;
            end else begin
                w_ctl[gi].op = CELL_HOLD;
            end
        end

        bdks_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl[gi]),
            .i_prev  (w_prev),
            .i_next  (w_next),
            .i_load  (w_new),
            .o_entry (w_cell[gi])
        );
    end

    // Running search result during a scan.
    always_comb begin
        n_hit  = r_hit;
        n_best = r_best;
        if (w_match) begin
            n_hit  = 1'b1;
            n_best = w_wrap;
        end else if (w_scan && (r_req.req_type == REQ_FIND_MAX) && w_pos_valid
                     && ((r_pos == '0) || (w_head.value > r_best.value))) begin
            n_hit  = 1'b1;
            n_best = w_head;
        end
    end

    // Next state, count and result beat.
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_valid  = 1'b0;
        n_result = '{status: STATUS_OK, out_key: '0, out_value: '0,
                     stored_count: COUNT_W'(r_count)};
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_valid = 1'b1;
                    unique case (i_req.req_type)
                        REQ_PUSH_BACK, REQ_PUSH_FRONT: begin
                            if (w_full) begin
                                n_result.status = STATUS_FULL;
                            end else begin
                                n_count            = r_count + CW'(1);
                                n_result.out_key   = i_req.item_key;
                                n_result.out_value = i_req.item_value;
                            end
                        end
                        REQ_POP_FRONT, REQ_POP_BACK: begin
                            if (w_empty) begin
                                n_result.status = STATUS_EMPTY;
                            end else begin
                                n_count = w_count_m1;
                                if (i_req.req_type == REQ_POP_FRONT) begin
                                    n_result.out_key   = w_head.key;
                                    n_result.out_value = w_head.value;
                                end else begin
                                    n_result.out_key   = w_back.key;
                                    n_result.out_value = w_back.value;
                                end
                            end
                        end
                        REQ_FIND, REQ_SET_VALUE, REQ_FIND_MAX: begin
                            if (w_empty) begin
                                n_result.status = STATUS_EMPTY;
                            end else begin
                                n_valid = 1'b0;
                                n_state = ST_SCAN;
                            end
                        end
                        default: begin
                            n_result.status = STATUS_OK;
                        end
                    endcase
                    n_result.stored_count = COUNT_W'(n_count);
                end
            end
            ST_SCAN: begin
                if (w_last) begin
                    n_state = ST_IDLE;
                    n_valid = 1'b1;
                    if (n_hit) begin
                        n_result.out_key   = n_best.key;
                        n_result.out_value = n_best.value;
                    end else begin
                        n_result.status = STATUS_NO_KEY;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State, count, scan registers and registered result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_pos   <= '0;
            r_hit   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
            if (w_accept) begin
                r_pos <= '0;
                r_hit <= 1'b0;
            end else if (w_scan) begin
                r_pos <= r_pos + PW'(1);
                r_hit <= n_hit;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= i_req;
        end
        if (w_scan) begin
            r_best <= n_best;
        end
        r_result <= n_result;
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

    // The count never passes the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count exceeds capacity");

    // No result beat appears while a scan is running.
    a_no_valid_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !o_valid)
        else $error("result strobe during scan");

    // Push and pop requests answer in the next cycle.
    a_fast_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && ((i_req.req_type == REQ_PUSH_BACK) || (i_req.req_type == REQ_PUSH_FRONT)
                      || (i_req.req_type == REQ_POP_FRONT)
                      || (i_req.req_type == REQ_POP_BACK))) |=> o_valid)
        else $error("push or pop result missing");

    // A search on a non-empty store starts a scan.
    a_scan_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_empty && ((i_req.req_type == REQ_FIND)
                                  || (i_req.req_type == REQ_SET_VALUE)
                                  || (i_req.req_type == REQ_FIND_MAX))) |=> busy)
        else $error("search did not start a scan");

    // The count does not change during a scan.
    a_count_stable_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> $stable(r_count))
        else $error("entry count changed during scan");

endmodule
